// ----- rtl/core/zbh_pkg.sv -----
// ----------------------------------------------------------------------------
// zbh_pkg
// Shared types, codes and the key generator step for the Zobrist hasher.
// ----------------------------------------------------------------------------
package zbh_pkg;

    // generator seed, also the reset value of the generator state
    localparam logic [63:0] SEED = 64'h9E3779B97F4A7C15;

    // castle table size, fixed by the four castling flags
    localparam int CASTLE_KEYS = 16;

    // command codes
    typedef enum logic [2:0] {
        CMD_INIT          = 3'd0,
        CMD_TOGGLE_PIECE  = 3'd1,
        CMD_TOGGLE_CASTLE = 3'd2,
        CMD_TOGGLE_SIDE   = 3'd3,
        CMD_TOGGLE_EP     = 3'd4,
        CMD_SCAN          = 3'd5,
        CMD_FINISH        = 3'd6
    } zbh_cmd_t;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_ISSUE,
        ST_DRAIN
    } zbh_state_t;

    // one xorshift64 step (shifts 13, 7, 17)
    function automatic logic [63:0] xorshift64(input logic [63:0] x);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        a = x ^ (x << 13);
        b = a ^ (a >> 7);
        c = b ^ (b << 17);
        return c;
    endfunction

endpackage

// ----- rtl/core/zbh_if.sv -----
// ----------------------------------------------------------------------------
// zbh_cmd_if / zbh_key_if
// Valid/ready channels of the hasher: command items in, hash keys out.
// ----------------------------------------------------------------------------
interface zbh_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  cmd;
    logic [3:0]  piece_kind;
    logic [5:0]  square;
    logic [63:0] board_bits;
    logic [3:0]  castle_rights;
    logic [6:0]  ep_square;
    logic        white_to_move;

    modport source (
        output valid, cmd, piece_kind, square, board_bits, castle_rights,
               ep_square, white_to_move,
        input  ready
    );
    modport sink (
        input  valid, cmd, piece_kind, square, board_bits, castle_rights,
               ep_square, white_to_move,
        output ready
    );
endinterface

interface zbh_key_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_key;

    modport source (
        output valid, hash_key,
        input  ready
    );
    modport sink (
        input  valid, hash_key,
        output ready
    );
endinterface

// ----- rtl/core/zbh_key_ram.sv -----
// ----------------------------------------------------------------------------
// zbh_key_ram
// Key storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module zbh_key_ram #(
    parameter int DEPTH = 1105,
    parameter int AW    = 11
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [63:0]   wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [63:0]   rdata
);

    logic [63:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- rtl/core/zobrist_board_hash_core.sv -----
// ----------------------------------------------------------------------------
// zobrist_board_hash_core
// 64-bit Zobrist hasher: key table fill, incremental toggles, bitboard scans
// and final key assembly around one shared key memory.
// ----------------------------------------------------------------------------
//  channel  | dir | payload
//  ---------+-----+----------------------------------------------------------
//  cmd_ch   | in  | cmd, piece_kind, square, board_bits, castle_rights,
//           |     | ep_square, white_to_move
//  key_ch   | out | hash_key (one transfer per command)
//
//  one command at a time, one key memory read or write per cycle
//  toggles read at most one key; finish steps through the side, castle and
//  en-passant keys in turn; scan reads one key per set bit; init writes every
//  key of the table from the generator
//  a waiting result stalls the drain of the next command, not its transfer
//  reset clears the running key, accumulator and control, not the key memory
// ----------------------------------------------------------------------------
module zobrist_board_hash_core
    import zbh_pkg::*;
#(
    parameter int PIECE_KINDS   = 13,
    parameter int BOARD_SQUARES = 64
) (
    input  logic      clk,
    input  logic      rst_n,
    zbh_cmd_if.sink   cmd_ch,
    zbh_key_if.source key_ch
);

    // memory layout: piece keys, side key, castle keys, en-passant keys
    localparam int SIDE_ADDR   = PIECE_KINDS * BOARD_SQUARES;
    localparam int CASTLE_BASE = SIDE_ADDR + 1;
    localparam int EP_BASE     = CASTLE_BASE + CASTLE_KEYS;
    localparam int TOTAL       = EP_BASE + BOARD_SQUARES;
    localparam int AW          = $clog2(TOTAL);
    localparam int SQW         = $clog2(BOARD_SQUARES);

    zbh_state_t             state_reg, state_next;
    zbh_cmd_t               cmd_reg;
    logic [5:0]             sq_reg;
    logic [3:0]             castle_reg;
    logic [6:0]             ep_reg;
    logic                   white_reg;
    logic                   kind_ok_reg;
    logic [AW-1:0]          base_reg;
    logic [BOARD_SQUARES-1:0] scan_bits_reg, scan_bits_next;
    logic [1:0]             step_reg, step_next;
    logic [AW-1:0]          init_cnt_reg, init_cnt_next;
    logic [63:0]            rng_reg, rng_next;
    logic [63:0]            acc_reg, acc_next;
    logic [63:0]            running_key_reg, running_key_next;
    logic [63:0]            full_accum_reg, full_accum_next;
    logic                   out_valid_reg, out_valid_next;
    logic [63:0]            hash_key_reg, hash_key_next;
    logic                   hit_reg;

    logic                   accept;
    logic                   out_free;
    logic                   finish_out;
    logic                   sq_ok;
    logic                   ep_ok;
    logic [63:0]            draw;
    logic [BOARD_SQUARES-1:0] scan_low;
    logic [BOARD_SQUARES-1:0] scan_rest;
    logic [SQW-1:0]         low_idx;
    logic                   ram_we;
    logic                   ram_re;
    logic [AW-1:0]          ram_raddr;
    logic [63:0]            ram_rdata;
    zbh_cmd_t               in_cmd;

    // handshake
    assign in_cmd       = zbh_cmd_t'(cmd_ch.cmd);
    assign cmd_ch.ready = (state_reg == ST_IDLE);
    assign accept       = cmd_ch.valid && cmd_ch.ready;
    assign out_free     = !out_valid_reg || key_ch.ready;
    assign key_ch.valid    = out_valid_reg;
    assign key_ch.hash_key = hash_key_reg;

    // range checks on the captured fields
    assign sq_ok = ({1'b0, sq_reg} < 7'(BOARD_SQUARES));
    assign ep_ok = (ep_reg < 7'(BOARD_SQUARES));
    assign draw  = xorshift64(rng_reg);

    // lowest set bit of the remaining scan bits and its square
    assign scan_low  = scan_bits_reg & (~scan_bits_reg + 1'b1);
    assign scan_rest = scan_bits_reg & (scan_bits_reg - 1'b1);

    always_comb
    begin
        low_idx = '0;
        for (int i = 0; i < BOARD_SQUARES; i++)
        begin
            if (scan_low[i])
            begin
                low_idx = low_idx | SQW'(i);
            end
        end
    end

    assign finish_out = (state_reg == ST_DRAIN) && !hit_reg && out_free;

    // key memory
    zbh_key_ram #(
        .DEPTH (TOTAL),
        .AW    (AW)
    ) u_key_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (init_cnt_reg),
        .wdata (draw),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // sequencer next state and outputs
    always_comb
    begin
        state_next       = state_reg;
        scan_bits_next   = scan_bits_reg;
        step_next        = step_reg;
        init_cnt_next    = init_cnt_reg;
        rng_next         = rng_reg;
        acc_next         = hit_reg ? (acc_reg ^ ram_rdata) : acc_reg;
        running_key_next = running_key_reg;
        full_accum_next  = full_accum_reg;
        out_valid_next   = out_valid_reg && !key_ch.ready;
        hash_key_next    = hash_key_reg;
        ram_we           = 1'b0;
        ram_re           = 1'b0;
        ram_raddr        = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    acc_next       = (in_cmd == CMD_SCAN || in_cmd == CMD_FINISH) ?
                                     full_accum_reg : running_key_reg;
                    step_next      = '0;
                    scan_bits_next = cmd_ch.board_bits[BOARD_SQUARES-1:0];
                    if (in_cmd == CMD_INIT)
                    begin
                        rng_next      = SEED;
                        init_cnt_next = '0;
                        state_next    = ST_INIT;
                    end
                    else
                    begin
                        state_next = ST_ISSUE;
                    end
                end
            end

            // one draw written per cycle, in memory order
            ST_INIT:
            begin
                ram_we        = 1'b1;
                rng_next      = draw;
                init_cnt_next = init_cnt_reg + 1'b1;
                if (init_cnt_reg == AW'(TOTAL - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end

            // issue key reads, each result folds into the accumulator in the cycle after its read
            ST_ISSUE:
            begin
                unique case (cmd_reg)
                    CMD_TOGGLE_PIECE:
                    begin
                        ram_re     = kind_ok_reg && sq_ok;
                        ram_raddr  = base_reg + AW'(sq_reg);
                        state_next = ST_DRAIN;
                    end
                    CMD_TOGGLE_CASTLE:
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = AW'(CASTLE_BASE) + AW'(castle_reg);
                        state_next = ST_DRAIN;
                    end
                    CMD_TOGGLE_SIDE:
                    begin
                        ram_re     = 1'b1;
                        ram_raddr  = AW'(SIDE_ADDR);
                        state_next = ST_DRAIN;
                    end
                    CMD_TOGGLE_EP:
                    begin
                        ram_re     = ep_ok;
                        ram_raddr  = AW'(EP_BASE) + AW'(ep_reg);
                        state_next = ST_DRAIN;
                    end
                    CMD_SCAN:
                    begin
                        if (kind_ok_reg && (scan_bits_reg != '0))
                        begin
                            ram_re         = 1'b1;
                            ram_raddr      = base_reg + AW'(low_idx);
                            scan_bits_next = scan_rest;
                            if (scan_rest == '0)
                            begin
                                state_next = ST_DRAIN;
                            end
                        end
                        else
                        begin
                            state_next = ST_DRAIN;
                        end
                    end
                    CMD_FINISH:
                    begin
                        step_next = step_reg + 1'b1;
                        priority if (step_reg == 2'd0)
                        begin
                            ram_re    = white_reg;
                            ram_raddr = AW'(SIDE_ADDR);
                        end
                        else if (step_reg == 2'd1)
                        begin
                            ram_re    = 1'b1;
                            ram_raddr = AW'(CASTLE_BASE) + AW'(castle_reg);
                        end
                        else
                        begin
                            ram_re     = ep_ok;
                            ram_raddr  = AW'(EP_BASE) + AW'(ep_reg);
                            state_next = ST_DRAIN;
                        end
                    end
                    default:
                    begin
                        state_next = ST_DRAIN;
                    end
                endcase
            end

            // last read folded in, hand the result to the output register
            ST_DRAIN:
            begin
                if (finish_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    unique case (cmd_reg)
                        CMD_TOGGLE_PIECE, CMD_TOGGLE_CASTLE,
                        CMD_TOGGLE_SIDE, CMD_TOGGLE_EP:
                        begin
                            running_key_next = acc_reg;
                            hash_key_next    = acc_reg;
                        end
                        CMD_SCAN:
                        begin
                            full_accum_next = acc_reg;
                            hash_key_next   = acc_reg;
                        end
                        CMD_FINISH:
                        begin
                            full_accum_next = '0;
                            hash_key_next   = acc_reg;
                        end
                        default:
                        begin
                            hash_key_next = '0;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and key state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            step_reg        <= '0;
            init_cnt_reg    <= '0;
            rng_reg         <= SEED;
            running_key_reg <= '0;
            full_accum_reg  <= '0;
            out_valid_reg   <= 1'b0;
            hit_reg         <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            step_reg        <= step_next;
            init_cnt_reg    <= init_cnt_next;
            rng_reg         <= rng_next;
            running_key_reg <= running_key_next;
            full_accum_reg  <= full_accum_next;
            out_valid_reg   <= out_valid_next;
            hit_reg         <= ram_re;
        end
    end

    // captured command fields and datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg       <= acc_next;
        scan_bits_reg <= scan_bits_next;
        hash_key_reg  <= hash_key_next;
        if (accept)
        begin
            cmd_reg     <= in_cmd;
            sq_reg      <= cmd_ch.square;
            castle_reg  <= cmd_ch.castle_rights;
            ep_reg      <= cmd_ch.ep_square;
            white_reg   <= cmd_ch.white_to_move;
            kind_ok_reg <= ({1'b0, cmd_ch.piece_kind} < 5'(PIECE_KINDS));
            base_reg    <= AW'(cmd_ch.piece_kind) * AW'(BOARD_SQUARES);
        end
    end

`ifndef SYNTHESIS
    // read data only arrives after a read issued by the sequencer
    a_hit_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
        hit_reg |-> $past(state_reg == ST_ISSUE))
        else $error("key read data without an issued read");

    // a new result is loaded only when the drain completes
    a_load_from_drain: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DRAIN))
        else $error("result loaded outside drain");

    // finish clears the accumulator
    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (finish_out && cmd_reg == CMD_FINISH) |=> (full_accum_reg == '0))
        else $error("accumulator not cleared after finish");

    // table fill stays inside the key memory
    a_init_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INIT) |-> (init_cnt_reg <= AW'(TOTAL - 1)))
        else $error("init counter beyond key memory");
`endif

endmodule
